### rtl/mda_pkg.sv
// Package for the multi-dimensional array store: field widths, codes,
// default parameter values and the element truncate and extend functions.
// Depends on nothing.
package mda_pkg;

    localparam int MAX_DIMS_DEF    = 4;
    localparam int STORE_DEPTH_DEF = 1024;

    localparam int IDX_FIELDS = 4;
    localparam int SEL_W      = 2;
    localparam int IDX_W      = 32;
    localparam int VAL_W      = 64;
    localparam int DSIZE_W    = 11;
    localparam int CNT_W      = 3;
    localparam int TYPE_W     = 3;
    localparam int KIND_W     = 2;
    localparam int STAT_W     = 3;
    localparam int BAD_W      = 2;
    localparam int OFF_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 3'd0,
        ST_COUNT = 3'd1,
        ST_RANGE = 3'd2,
        ST_KIND  = 3'd3,
        ST_UNDIM = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM_COUNT  = 3'd0,
        CFG_ELEM_TYPE  = 3'd1,
        CFG_DIM_SIZE_0 = 3'd2,
        CFG_DIM_SIZE_1 = 3'd3,
        CFG_DIM_SIZE_2 = 3'd4,
        CFG_DIM_SIZE_3 = 3'd5
    } t_cfg_reg;

    localparam logic              ACT_WRITE = 1'b1;
    localparam logic [KIND_W-1:0] KIND_INT  = 2'd0;

    localparam logic [1:0] WC_64 = 2'd0;
    localparam logic [1:0] WC_32 = 2'd1;
    localparam logic [1:0] WC_16 = 2'd2;
    localparam logic [1:0] WC_8  = 2'd3;
    localparam int         TYPE_UNSIGNED_BIT = 2;

    function automatic logic [VAL_W-1:0] truncate_elem(input logic [VAL_W-1:0] v,
                                                       input logic [TYPE_W-1:0] t);
        logic [VAL_W-1:0] r;
        unique case (t[1:0])
            WC_64: r = v;
            WC_32: r = {32'd0, v[31:0]};
            WC_16: r = {48'd0, v[15:0]};
            WC_8:  r = {56'd0, v[7:0]};
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] extend_elem(input logic [VAL_W-1:0] v,
                                                     input logic [TYPE_W-1:0] t);
        logic [VAL_W-1:0] r;
        logic             sx;
        sx = ~t[TYPE_UNSIGNED_BIT];
        unique case (t[1:0])
            WC_64: r = v;
            WC_32: r = {{32{sx & v[31]}}, v[31:0]};
            WC_16: r = {{48{sx & v[15]}}, v[15:0]};
            WC_8:  r = {{56{sx & v[7]}}, v[7:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

### rtl/mda_if.sv
// Valid/ready channel interfaces for the array store: request, response
// and register write. Depends on mda_pkg for the field widths.
interface mda_in_if;
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic [mda_pkg::CNT_W-1:0]         index_count;
    logic signed [mda_pkg::IDX_W-1:0]  index_0;
    logic signed [mda_pkg::IDX_W-1:0]  index_1;
    logic signed [mda_pkg::IDX_W-1:0]  index_2;
    logic signed [mda_pkg::IDX_W-1:0]  index_3;
    logic signed [mda_pkg::VAL_W-1:0]  write_value;
    logic [mda_pkg::KIND_W-1:0]        register_kind;

    modport source (output valid, action, index_count, index_0, index_1, index_2,
                    index_3, write_value, register_kind, input ready);
    modport sink (input valid, action, index_count, index_0, index_1, index_2,
                  index_3, write_value, register_kind, output ready);
endinterface

interface mda_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [mda_pkg::VAL_W-1:0]  read_value;
    logic [mda_pkg::STAT_W-1:0]        status;
    logic [mda_pkg::BAD_W-1:0]         bad_dimension;
    logic [mda_pkg::OFF_W-1:0]         flat_offset;

    modport source (output valid, read_value, status, bad_dimension, flat_offset,
                    input ready);
    modport sink (input valid, read_value, status, bad_dimension, flat_offset,
                  output ready);
endinterface

interface mda_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mda_pkg::CFG_IDX_W-1:0]     index;
    logic [mda_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/mda_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module mda_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/multidim_array_access.sv
// Multi-dimensional typed array store: row-major flattening on one shared
// multiplier under a small sequencer, element store in mda_ram.
// Depends on mda_pkg, mda_if and mda_ram.
// Sequence: a wrong index count goes straight to the response; else one multiply a
// step builds the size product (too large: not dimensioned), then again the offset
// (an index or register kind failure ends there), then the store is written, or read
// and extended, before the response, which waits while the output is still held.
// Throughput: one request at a time; the next is taken once the response is registered.
// Reset: synchronous; a clearing pass then zeroes every word of the store,
// during which no request is taken while register writes are.
module multidim_array_access #(
    parameter int MAX_DIMS    = mda_pkg::MAX_DIMS_DEF,
    parameter int STORE_DEPTH = mda_pkg::STORE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mda_cfg_if.sink    i_cfg,
    mda_in_if.sink     i_req,
    mda_out_if.source  o_rsp
);

    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int PW   = $clog2(STORE_DEPTH + 2);
    localparam int MW   = PW + mda_pkg::DSIZE_W;
    localparam int SUPD = (MAX_DIMS < mda_pkg::IDX_FIELDS) ? MAX_DIMS : mda_pkg::IDX_FIELDS;

    typedef enum logic [2:0] {S_IDLE, S_PROD, S_MAC, S_MEM, S_RD, S_FIN} t_state;

    logic [mda_pkg::CNT_W-1:0]   r_dim_count;
    logic [mda_pkg::TYPE_W-1:0]  r_elem_type;
    logic [mda_pkg::DSIZE_W-1:0] r_dim_size [mda_pkg::IDX_FIELDS];

    t_state                      r_state, n_state;
    logic                        r_clearing;
    logic [AW-1:0]               r_clr_addr;
    logic [mda_pkg::SEL_W-1:0]   r_step, n_step;
    logic [PW-1:0]               r_prod, n_prod;
    logic [AW-1:0]               r_offset, n_offset;
    logic                        r_fail, n_fail;
    logic [mda_pkg::BAD_W-1:0]   r_bad, n_bad;
    mda_pkg::t_status            r_status, n_status;
    logic [mda_pkg::VAL_W-1:0]   r_rval, n_rval;
    logic                        r_act;
    logic [mda_pkg::KIND_W-1:0]  r_kind;
    logic [mda_pkg::VAL_W-1:0]   r_wval;
    logic [mda_pkg::IDX_W-1:0]   r_idx [mda_pkg::IDX_FIELDS];

    logic                        r_out_valid, n_out_valid;
    logic [mda_pkg::VAL_W-1:0]   r_out_rval, n_out_rval;
    logic [mda_pkg::STAT_W-1:0]  r_out_status, n_out_status;
    logic [mda_pkg::BAD_W-1:0]   r_out_bad, n_out_bad;
    logic [mda_pkg::OFF_W-1:0]   r_out_off, n_out_off;

    logic                        w_req_acc;
    logic                        w_count_ok;
    logic [mda_pkg::CNT_W-1:0]   w_last_cnt;
    logic                        w_last;
    logic [mda_pkg::DSIZE_W-1:0] w_size;
    logic [mda_pkg::IDX_W-1:0]   w_idx;
    logic                        w_idx_fail;
    logic [PW-1:0]               w_mul_a;
    logic [MW-1:0]               w_mul;
    logic [MW-1:0]               w_mac;
    logic [PW-1:0]               w_prod_sat;
    logic [AW+mda_pkg::OFF_W-1:0] w_off_ext;

    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic [mda_pkg::VAL_W-1:0]   w_wdata;
    logic [mda_pkg::VAL_W-1:0]   w_rdata;

    mda_ram #(
        .WIDTH (mda_pkg::VAL_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_offset),
        .o_rdata (w_rdata)
    );

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE) && !r_clearing;
    assign w_req_acc   = i_req.valid && i_req.ready;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.read_value    = r_out_rval;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.bad_dimension = r_out_bad;
    assign o_rsp.flat_offset   = r_out_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count <= mda_pkg::CNT_W'(1);
            r_elem_type <= '0;
            for (int k = 0; k < mda_pkg::IDX_FIELDS; k++) begin
                r_dim_size[k] <= '0;
            end
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mda_pkg::CFG_DIM_COUNT:  r_dim_count   <= i_cfg.data[mda_pkg::CNT_W-1:0];
                mda_pkg::CFG_ELEM_TYPE:  r_elem_type   <= i_cfg.data[mda_pkg::TYPE_W-1:0];
                mda_pkg::CFG_DIM_SIZE_0: r_dim_size[0] <= i_cfg.data;
                mda_pkg::CFG_DIM_SIZE_1: r_dim_size[1] <= i_cfg.data;
                mda_pkg::CFG_DIM_SIZE_2: r_dim_size[2] <= i_cfg.data;
                mda_pkg::CFG_DIM_SIZE_3: r_dim_size[3] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(STORE_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign w_count_ok = (r_dim_count != '0) && (r_dim_count <= mda_pkg::CNT_W'(SUPD))
                        && (i_req.index_count == r_dim_count);
    assign w_last_cnt = r_dim_count - 1'b1;
    assign w_last     = (r_step == w_last_cnt[mda_pkg::SEL_W-1:0]);
    assign w_size     = r_dim_size[r_step];
    assign w_idx      = r_idx[r_step];
    assign w_idx_fail = w_idx[mda_pkg::IDX_W-1]
                        || (w_idx[mda_pkg::IDX_W-2:0] >= (mda_pkg::IDX_W-1)'(w_size));

    // The shared multiplier serves the size product first, then the offset.
    assign w_mul_a    = (r_state == S_PROD) ? r_prod : PW'(r_offset);
    assign w_mul      = MW'(w_mul_a) * MW'(w_size);
    assign w_mac      = w_mul + MW'(w_idx[mda_pkg::DSIZE_W-1:0]);
    assign w_prod_sat = (w_mul > MW'(STORE_DEPTH)) ? PW'(STORE_DEPTH + 1) : w_mul[PW-1:0];
    assign w_off_ext  = {{mda_pkg::OFF_W{1'b0}}, r_offset};

    assign w_we    = r_clearing || ((r_state == S_MEM) && (r_act == mda_pkg::ACT_WRITE));
    assign w_waddr = r_clearing ? r_clr_addr : r_offset;
    assign w_wdata = r_clearing ? '0 : mda_pkg::truncate_elem(r_wval, r_elem_type);

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_prod       = r_prod;
        n_offset     = r_offset;
        n_fail       = r_fail;
        n_bad        = r_bad;
        n_status     = r_status;
        n_rval       = r_rval;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_rval   = r_out_rval;
        n_out_status = r_out_status;
        n_out_bad    = r_out_bad;
        n_out_off    = r_out_off;
        unique case (r_state)
            S_IDLE: begin
                if (w_req_acc) begin
                    n_step   = '0;
                    n_prod   = PW'(1);
                    n_offset = '0;
                    n_fail   = 1'b0;
                    n_bad    = '0;
                    n_rval   = '0;
                    n_status = mda_pkg::ST_OK;
                    if (w_count_ok) begin
                        n_state = S_PROD;
                    end else begin
                        n_status = mda_pkg::ST_COUNT;
                        n_state  = S_FIN;
                    end
                end
            end
            S_PROD: begin
                n_prod = w_prod_sat;
                n_step = r_step + 1'b1;
                if (w_last) begin
                    n_step = '0;
                    if (w_prod_sat > PW'(STORE_DEPTH)) begin
                        n_status = mda_pkg::ST_UNDIM;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_MAC;
                    end
                end
            end
            S_MAC: begin
                n_offset = w_mac[AW-1:0];
                n_step   = r_step + 1'b1;
                if (w_idx_fail) begin
                    n_fail = 1'b1;
                    n_bad  = r_step;
                end
                if (w_last) begin
                    priority if (r_fail || w_idx_fail) begin
                        n_status = mda_pkg::ST_RANGE;
                        n_state  = S_FIN;
                    end else if (r_kind != mda_pkg::KIND_INT) begin
                        n_status = mda_pkg::ST_KIND;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_MEM;
                    end
                end
            end
            S_MEM: begin
                n_state = (r_act == mda_pkg::ACT_WRITE) ? S_FIN : S_RD;
            end
            S_RD: begin
                n_rval  = mda_pkg::extend_elem(w_rdata, r_elem_type);
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_rval   = r_rval;
                    n_out_status = r_status;
                    n_out_bad    = (r_status == mda_pkg::ST_RANGE) ? r_bad : '0;
                    n_out_off    = (r_status == mda_pkg::ST_OK)
                                   ? w_off_ext[mda_pkg::OFF_W-1:0] : '0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_fail      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            r_fail      <= n_fail;
        end
        r_prod       <= n_prod;
        r_offset     <= n_offset;
        r_bad        <= n_bad;
        r_status     <= n_status;
        r_rval       <= n_rval;
        r_out_rval   <= n_out_rval;
        r_out_status <= n_out_status;
        r_out_bad    <= n_out_bad;
        r_out_off    <= n_out_off;
        if (w_req_acc) begin
            r_act    <= i_req.action;
            r_kind   <= i_req.register_kind;
            r_wval   <= i_req.write_value;
            r_idx[0] <= i_req.index_0;
            r_idx[1] <= i_req.index_1;
            r_idx[2] <= i_req.index_2;
            r_idx[3] <= i_req.index_3;
        end
    end

    a_fail_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != mda_pkg::ST_OK))
        |-> ((o_rsp.read_value == '0) && (o_rsp.flat_offset == '0)))
        else $error("failed request returned a value or offset");

    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (r_state == S_IDLE))
        else $error("request in progress during the clearing pass");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_acc |=> (r_state != S_IDLE))
        else $error("accepted request did not start the sequencer");

    a_mem_only_when_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MEM) |-> (r_status == mda_pkg::ST_OK))
        else $error("store accessed for a failing request");

endmodule

### test/tb.sv
// Testbench for multidim_array_access: directed and randomised element reads and writes,
// each response checked field by field against a behavioural model of the array store.
// Depends on mda_pkg, the channel interfaces in mda_if.sv and the block itself.
`timescale 1ns / 100ps

module tb;
    import mda_pkg::*;

    localparam int LIMIT_CYCLES   = 5000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int MAX_GAP        = 19;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASES         = 22;
    localparam int PHASE_ITEMS    = 40;
    localparam int PRESSURE_PHASE = 5;
    localparam int SUPPORTED_DIMS = (MAX_DIMS_DEF < IDX_FIELDS) ? MAX_DIMS_DEF : IDX_FIELDS;

    localparam logic              ACT_READ = ~ACT_WRITE;
    localparam logic [KIND_W-1:0] KIND_NUM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OBJ = 2'd3;

    localparam logic [TYPE_W-1:0] ET_I64 = 3'd0;
    localparam logic [TYPE_W-1:0] ET_I32 = 3'd1;
    localparam logic [TYPE_W-1:0] ET_I16 = 3'd2;
    localparam logic [TYPE_W-1:0] ET_I8  = 3'd3;
    localparam logic [TYPE_W-1:0] ET_U64 = 3'd4;
    localparam logic [TYPE_W-1:0] ET_U32 = 3'd5;
    localparam logic [TYPE_W-1:0] ET_U16 = 3'd6;
    localparam logic [TYPE_W-1:0] ET_U8  = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(CFG_DIM_SIZE_3 + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    typedef struct packed {
        logic                             action;
        logic [CNT_W-1:0]                 index_count;
        logic [IDX_FIELDS-1:0][IDX_W-1:0] index;
        logic [VAL_W-1:0]                 write_value;
        logic [KIND_W-1:0]                register_kind;
    } t_request;

    typedef struct packed {
        logic [VAL_W-1:0] read_value;
        t_status          status;
        logic [BAD_W-1:0] bad_dimension;
        logic [OFF_W-1:0] flat_offset;
    } t_response;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mda_cfg_if cfg_ch ();
    mda_in_if  req_ch ();
    mda_out_if rsp_ch ();

    logic [VAL_W-1:0]   shadow_store [STORE_DEPTH_DEF];
    logic [CNT_W-1:0]   shadow_count;
    logic [TYPE_W-1:0]  shadow_type;
    logic [DSIZE_W-1:0] shadow_size [IDX_FIELDS];

    t_response pending_results [$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    int        hold_request   = 0;
    bit        src_idle_on    = 1'b1;
    bit        snk_idle_on    = 1'b1;

    multidim_array_access dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    // Expected response of one request; a successful write updates the shadow store.
    function automatic t_response access_element(input t_request r);
        t_response        res;
        logic [63:0]      span;
        logic [63:0]      stride;
        logic [63:0]      offset;
        logic [63:0]      mask;
        logic [63:0]      word;
        logic [IDX_W-1:0] raw;
        int               n;
        int               width;
        res        = '0;
        res.status = ST_OK;
        offset     = 64'd0;
        n          = int'(shadow_count);
        if (n == 0 || n > SUPPORTED_DIMS || r.index_count != shadow_count) begin
            res.status = ST_COUNT;
        end else begin
            span = 64'd1;
            for (int i = 0; i < n; i++) span = span * shadow_size[i];
            if (span > STORE_DEPTH_DEF) begin
                res.status = ST_UNDIM;
            end else begin
                stride = 64'd1;
                for (int i = n - 1; i >= 0; i--) begin
                    raw = r.index[i];
                    if (res.status == ST_OK) begin
                        if (raw[IDX_W-1] || raw >= shadow_size[i]) begin
                            res.status        = ST_RANGE;
                            res.bad_dimension = BAD_W'(i);
                        end else begin
                            offset = offset + raw * stride;
                            stride = stride * shadow_size[i];
                        end
                    end
                end
                if (res.status == ST_OK && r.register_kind != KIND_INT) res.status = ST_KIND;
            end
        end
        if (res.status == ST_OK && offset < STORE_DEPTH_DEF) begin
            case (shadow_type[1:0])
                WC_64: width = 64;
                WC_32: width = 32;
                WC_16: width = 16;
                default: width = 8;
            endcase
            mask = (width == 64) ? '1 : ((64'd1 << width) - 64'd1);
            res.flat_offset = offset[OFF_W-1:0];
            if (r.action == ACT_WRITE) begin
                shadow_store[offset] = r.write_value & mask;
            end else begin
                word = shadow_store[offset] & mask;
                if (!shadow_type[TYPE_UNSIGNED_BIT] && word[width-1]) word = word | ~mask;
                res.read_value = word;
            end
        end else if (res.status == ST_OK) begin
            res.status = ST_UNDIM;
        end
        return res;
    endfunction

    function automatic t_request build_request(input logic act, input int count,
                                               input int i0, input int i1, input int i2,
                                               input int i3, input logic [VAL_W-1:0] value,
                                               input logic [KIND_W-1:0] kind);
        t_request r;
        r.action        = act;
        r.index_count   = CNT_W'(count);
        r.index[0]      = i0;
        r.index[1]      = i1;
        r.index[2]      = i2;
        r.index[3]      = i3;
        r.write_value   = value;
        r.register_kind = kind;
        return r;
    endfunction

    // Mostly requests that match the current shape, with some noise mixed in.
    function automatic t_request random_request();
        t_request r;
        r.action      = 1'($urandom_range(1, 0));
        r.write_value = {$urandom, $urandom};
        if ($urandom_range(9, 0) == 0) begin
            case ($urandom_range(3, 0))
                0: r.write_value = {1'b1, {(VAL_W-1){1'b0}}};
                1: r.write_value = {1'b0, {(VAL_W-1){1'b1}}};
                2: r.write_value = '0;
                default: r.write_value = '1;
            endcase
        end
        if ($urandom_range(4, 0) != 0) begin
            if (shadow_count >= 1 && shadow_count <= SUPPORTED_DIMS)
                r.index_count = shadow_count;
            else
                r.index_count = CNT_W'($urandom_range(SUPPORTED_DIMS, 0));
            r.register_kind = ($urandom_range(9, 0) == 0) ? KIND_W'($urandom_range(3, 1))
                                                          : KIND_INT;
            for (int i = 0; i < IDX_FIELDS; i++) begin
                if (shadow_size[i] != 0 && $urandom_range(15, 0) != 0)
                    r.index[i] = $urandom_range(shadow_size[i] - 1, 0);
                else
                    r.index[i] = $urandom_range(shadow_size[i], 0);
            end
        end else begin
            r.index_count   = CNT_W'($urandom_range(SUPPORTED_DIMS, 0));
            r.register_kind = KIND_W'($urandom_range(3, 0));
            for (int i = 0; i < IDX_FIELDS; i++)
                r.index[i] = $urandom_range(1, 0) ? $urandom : $urandom_range(1100, 0);
        end
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_request(input t_request r);
        int gap;
        gap = src_idle_on ? $urandom_range(MAX_GAP, 0) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.action        <= r.action;
        req_ch.index_count   <= r.index_count;
        req_ch.index_0       <= r.index[0];
        req_ch.index_1       <= r.index[1];
        req_ch.index_2       <= r.index[2];
        req_ch.index_3       <= r.index[3];
        req_ch.write_value   <= r.write_value;
        req_ch.register_kind <= r.register_kind;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_results.push_back(access_element(r));
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_DIM_COUNT: shadow_count = data[CNT_W-1:0];
            CFG_ELEM_TYPE: shadow_type  = data[TYPE_W-1:0];
            CFG_DIM_SIZE_0, CFG_DIM_SIZE_1, CFG_DIM_SIZE_2, CFG_DIM_SIZE_3:
                shadow_size[idx - CFG_DIM_SIZE_0] = data;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] count,
                             input logic [CFG_DATA_W-1:0] etype,
                             input logic [CFG_DATA_W-1:0] s0, input logic [CFG_DATA_W-1:0] s1,
                             input logic [CFG_DATA_W-1:0] s2, input logic [CFG_DATA_W-1:0] s3);
        cfg_write(CFG_DIM_COUNT, count);
        cfg_write(CFG_ELEM_TYPE, etype);
        cfg_write(CFG_DIM_SIZE_0, s0);
        cfg_write(CFG_DIM_SIZE_1, s1);
        cfg_write(CFG_DIM_SIZE_2, s2);
        cfg_write(CFG_DIM_SIZE_3, s3);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_type(input logic [TYPE_W-1:0] etype);
        wait_idle();
        cfg_write(CFG_ELEM_TYPE, CFG_DATA_W'(etype));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Registers still hold their reset values: one dimension of size zero.
    task automatic test_reset_state();
        send_request(build_request(ACT_READ, 1, 0, 0, 0, 0, '0, KIND_INT));
        send_request(build_request(ACT_WRITE, 0, 0, 0, 0, 0, '1, KIND_INT));
        wait_idle();
    endtask

    task automatic test_element_access();
        configure(2, ET_I64, 4, 8, 0, 0);
        send_request(build_request(ACT_WRITE, 2, 3, 7, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF,
                                   KIND_INT));
        send_request(build_request(ACT_READ, 2, 3, 7, 0, 0, '0, KIND_INT));
        send_request(build_request(ACT_WRITE, 2, 0, 0, 0, 0, 64'h8000_0000_0000_0000,
                                   KIND_INT));
        send_request(build_request(ACT_READ, 2, 0, 0, 0, 0, '0, KIND_INT));
        send_request(build_request(ACT_READ, 2, 0, -1, 0, 0, '0, KIND_INT));
        send_request(build_request(ACT_READ, 2, 4, 8, 0, 0, '0, KIND_INT));
        send_request(build_request(ACT_READ, 2, 4, 0, 0, 0, '0, KIND_INT));
        send_request(build_request(ACT_WRITE, 2, 1, 1, 0, 0, '1, KIND_OBJ));
        send_request(build_request(ACT_READ, 2, 1, 1, 0, 0, '0, KIND_STR));
        send_request(build_request(ACT_READ, 2, 2, 2, 0, 0, '0, KIND_NUM));
        send_request(build_request(ACT_READ, 1, 1, 1, 0, 0, '0, KIND_INT));
        wait_idle();
    endtask

    // Stored bits stay put while the element type changes underneath them.
    task automatic test_element_types();
        configure(1, ET_I64, 16, 0, 0, 0);
        send_request(build_request(ACT_WRITE, 1, 5, 0, 0, 0, 64'h8081_8283_8485_8687,
                                   KIND_INT));
        set_type(ET_I32);
        send_request(build_request(ACT_READ, 1, 5, 0, 0, 0, '0, KIND_INT));
        set_type(ET_U32);
        send_request(build_request(ACT_READ, 1, 5, 0, 0, 0, '0, KIND_INT));
        set_type(ET_U16);
        send_request(build_request(ACT_READ, 1, 5, 0, 0, 0, '0, KIND_INT));
        set_type(ET_I8);
        send_request(build_request(ACT_READ, 1, 5, 0, 0, 0, '0, KIND_INT));
        set_type(ET_U8);
        send_request(build_request(ACT_READ, 1, 5, 0, 0, 0, '0, KIND_INT));
        set_type(ET_I16);
        send_request(build_request(ACT_WRITE, 1, 6, 0, 0, 0, 64'hFFFF_FFFF_FFFF_8F7F,
                                   KIND_INT));
        set_type(ET_U64);
        send_request(build_request(ACT_READ, 1, 6, 0, 0, 0, '0, KIND_INT));
        wait_idle();
    endtask

    task automatic test_shape_corners();
        configure(0, ET_I64, 4, 4, 4, 4);
        send_request(build_request(ACT_READ, 0, 0, 0, 0, 0, '0, KIND_INT));
        wait_idle();
        configure(SUPPORTED_DIMS + 1, ET_U8, 4, 4, 4, 4);
        send_request(build_request(ACT_READ, SUPPORTED_DIMS, 0, 0, 0, 0, '0, KIND_INT));
        wait_idle();
        configure(2, ET_I64, 1024, 2, 0, 0);
        send_request(build_request(ACT_READ, 2, 0, 0, 0, 0, '0, KIND_INT));
        wait_idle();
        configure(3, ET_I64, 4, 0, 8, 0);
        send_request(build_request(ACT_READ, 3, 0, 0, 7, 0, '0, KIND_INT));
        wait_idle();
        configure(4, ET_U64, 4, 4, 8, 8);
        send_request(build_request(ACT_WRITE, 4, 3, 3, 7, 7, '1, KIND_INT));
        send_request(build_request(ACT_READ, 4, 3, 3, 7, 7, '0, KIND_INT));
        wait_idle();
        // Writes to unmapped register indices must leave the shape untouched.
        cfg_write(CFG_SPARE_LO, '1);
        cfg_write(CFG_SPARE_HI, '0);
        cfg_ch.valid <= 1'b0;
        send_request(build_request(ACT_READ, 4, 3, 3, 7, 7, '0, KIND_INT));
        wait_idle();
    endtask

    task automatic random_config();
        logic [CFG_DATA_W-1:0] sz [IDX_FIELDS];
        int                    room;
        int                    count;
        int                    shape;
        if ($urandom_range(9, 0) == 0)
            count = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(7, SUPPORTED_DIMS + 1);
        else
            count = $urandom_range(SUPPORTED_DIMS, 1);
        room  = STORE_DEPTH_DEF;
        shape = $urandom_range(11, 0);
        for (int i = 0; i < IDX_FIELDS; i++) begin
            if (i >= count) begin
                sz[i] = CFG_DATA_W'($urandom_range(STORE_DEPTH_DEF, 0));
            end else if (shape == 0) begin
                sz[i] = CFG_DATA_W'($urandom_range(STORE_DEPTH_DEF, 1));
            end else begin
                if ($urandom_range(1, 0) == 0)
                    sz[i] = CFG_DATA_W'($urandom_range(room, 1));
                else
                    sz[i] = CFG_DATA_W'($urandom_range((room < 8) ? room : 8, 1));
                room = room / sz[i];
            end
        end
        if (shape == 1 && count >= 1 && count <= SUPPORTED_DIMS)
            sz[$urandom_range(count - 1, 0)] = '0;
        if ($urandom_range(4, 0) == 0)
            cfg_write($urandom_range(1, 0) ? CFG_SPARE_LO : CFG_SPARE_HI,
                      CFG_DATA_W'($urandom));
        configure(CFG_DATA_W'(count), CFG_DATA_W'($urandom_range(7, 0)),
                  sz[0], sz[1], sz[2], sz[3]);
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            random_config();
            src_idle_on = (p % 4 == 0) || (p % 4 == 2);
            snk_idle_on = (p % 4 == 0) || (p % 4 == 1);
            // The receiver stops for a long stretch while requests keep coming.
            if (p == PRESSURE_PHASE) hold_request = HOLD_CYCLES;
            repeat (PHASE_ITEMS) send_request(random_request());
        end
        wait_idle();
    endtask

    initial begin
        for (int a = 0; a < STORE_DEPTH_DEF; a++) shadow_store[a] = '0;
        for (int d = 0; d < IDX_FIELDS; d++) shadow_size[d] = '0;
        shadow_count = CNT_W'(1);
        shadow_type  = ET_I64;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= CFG_DIM_COUNT;
        cfg_ch.data          <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.action        <= ACT_READ;
        req_ch.index_count   <= '0;
        req_ch.index_0       <= '0;
        req_ch.index_1       <= '0;
        req_ch.index_2       <= '0;
        req_ch.index_3       <= '0;
        req_ch.write_value   <= '0;
        req_ch.register_kind <= KIND_INT;
        i_rst_n              <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_element_access();
        test_element_types();
        test_shape_corners();
        test_random_traffic();
        if (mismatch_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        int stall;
        rsp_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end else begin
                stall = snk_idle_on ? $urandom_range(MAX_GAP, 0) : 0;
            end
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
        end
    end

    always @(posedge i_clk) begin : check_responses
        t_response seen;
        t_response want;
        if (rsp_ch.valid && rsp_ch.ready) begin
            seen.read_value    = rsp_ch.read_value;
            seen.status        = t_status'(rsp_ch.status);
            seen.bad_dimension = rsp_ch.bad_dimension;
            seen.flat_offset   = rsp_ch.flat_offset;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("tb: response with no request outstanding: status %0d",
                             rsp_ch.status);
            end else begin
                want = pending_results.pop_front();
                if (seen.read_value !== want.read_value || seen.status !== want.status ||
                    seen.bad_dimension !== want.bad_dimension ||
                    seen.flat_offset !== want.flat_offset) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"tb: mismatch: read_value %h/%h status %0d/%0d ",
                                  "bad_dimension %0d/%0d flat_offset %0d/%0d"},
                                 want.read_value, seen.read_value, want.status, seen.status,
                                 want.bad_dimension, seen.bad_dimension,
                                 want.flat_offset, seen.flat_offset);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= LIMIT_CYCLES) begin
            $display("tb: done, errors");
            $finish;
        end
    end

endmodule

### multidim_array_access.f
rtl/mda_pkg.sv
rtl/mda_if.sv
rtl/mda_ram.sv
rtl/multidim_array_access.sv
test/tb.sv
